// ===== hw/rtl/rgbblur_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbblur_pkg
// Shared types, constants and per-channel filter math for the rgb565 blur.
// ----------------------------------------------------------------------------
package rgbblur_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_ENABLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESUME_COLUMNS    = 2'd3;

    localparam int PIX_W  = 16;
    localparam int CHAN_W = 8;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             row_start;
        logic             strip_start;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             column_overflow;
    } out_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] smoothing;
        logic              horizontal_enable;
        logic              vertical_enable;
        logic              resume_columns;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } chan3_t;

    localparam int CHAN3_W = 3 * CHAN_W;

    // nonzero words get their low bits filled with ones
    function automatic chan3_t unpack565(logic [PIX_W-1:0] w);
        chan3_t c;
        logic   fill;
        fill = |w;
        c.b  = {w[4:0],   (fill ? 3'h7 : 3'h0)};
        c.g  = {w[10:5],  (fill ? 2'h3 : 2'h0)};
        c.r  = {w[15:11], (fill ? 3'h7 : 3'h0)};
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] pack565(chan3_t c);
        return {c.r[7:3], c.g[7:2], c.b[7:3]};
    endfunction

    function automatic logic [8:0] gain_of(logic [CHAN_W-1:0] degree);
        return 9'd256 - {1'b0, degree};
    endfunction

    // acc + floor((p - acc) * gain / 256), wrapped to 8 bits
    function automatic logic [CHAN_W-1:0] iir_chan(logic [CHAN_W-1:0] acc,
                                                   logic [CHAN_W-1:0] p,
                                                   logic [8:0]        gain);
        logic signed [8:0]  diff;
        logic signed [9:0]  g;
        logic signed [18:0] prod;
        logic signed [18:0] q;
        diff = $signed({1'b0, p}) - $signed({1'b0, acc});
        g    = $signed({1'b0, gain});
        prod = diff * g;
        q    = prod >>> 8;
        return acc + q[7:0];
    endfunction

    function automatic chan3_t iir_step(chan3_t acc, chan3_t p, logic [8:0] gain);
        chan3_t n;
        n.r = iir_chan(acc.r, p.r, gain);
        n.g = iir_chan(acc.g, p.g, gain);
        n.b = iir_chan(acc.b, p.b, gain);
        return n;
    endfunction

endpackage

// ===== hw/rtl/rgbblur_ram.sv =====
// ----------------------------------------------------------------------------
// rgbblur_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rgbblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/rgbblur_fifo.sv =====
// ----------------------------------------------------------------------------
// rgbblur_fifo
// Short queue between the row pass and the column pass.
// ----------------------------------------------------------------------------
module rgbblur_fifo #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rgbblur_front.sv =====
// ----------------------------------------------------------------------------
// rgbblur_front
// Input side: column tracking and the row-direction filter pass.
// ----------------------------------------------------------------------------
module rgbblur_front import rgbblur_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     q_full,
    output logic     push,
    output logic [PIX_W+2+$clog2(MAX_WIDTH)-1:0] push_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0] col_reg, col_next;
    chan3_t           row_acc_reg, row_acc_next;
    logic             ovf;
    chan3_t           pix;
    chan3_t           seed;
    chan3_t           row_new;
    logic [PIX_W-1:0] hp;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        col_next     = col_reg;
        row_acc_next = row_acc_reg;
        ovf          = 1'b0;

        if (in_data.row_start)
        begin
            col_next = '0;
        end
        else if (col_reg >= COL_W'(MAX_WIDTH - 1))
        begin
            col_next = COL_W'(MAX_WIDTH - 1);
            ovf      = 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end

        pix     = unpack565(in_data.pixel_in);
        seed    = in_data.row_start ? pix : row_acc_reg;
        row_new = iir_step(seed, pix, gain_of(cfg.smoothing));
        hp      = in_data.pixel_in;
        if (cfg.horizontal_enable)
        begin
            row_acc_next = row_new;
            hp           = pack565(row_new);
        end
    end

    assign push_data = {hp, ovf, in_data.strip_start, col_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_acc_reg <= '0;
        end
        else if (push)
        begin
            col_reg     <= col_next;
            row_acc_reg <= row_acc_next;
        end
    end

endmodule

// ===== hw/rtl/rgbblur_back.sv =====
// ----------------------------------------------------------------------------
// rgbblur_back
// Column-direction filter pass over the per-column accumulator memory.
// ----------------------------------------------------------------------------
module rgbblur_back import rgbblur_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  logic [PIX_W+2+$clog2(MAX_WIDTH)-1:0] q_data,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ENT_W = PIX_W + 2 + COL_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic             state_reg, state_next;
    logic [ENT_W-1:0] ent_reg, ent_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             rd_en;
    logic             wr_en;
    logic [CHAN3_W-1:0] rd_data;
    logic [PIX_W-1:0] ent_hp;
    logic             ent_ovf;
    logic             ent_ss;
    logic [COL_W-1:0] ent_col;
    logic             slot_free;
    chan3_t           pix;
    chan3_t           acc;
    chan3_t           acc_new;
    logic [PIX_W-1:0] res;

    assign ent_hp  = ent_reg[ENT_W-1 -: PIX_W];
    assign ent_ovf = ent_reg[COL_W+1];
    assign ent_ss  = ent_reg[COL_W];
    assign ent_col = ent_reg[COL_W-1:0];

    assign slot_free = !out_valid_reg || !out_stall;

    rgbblur_ram #(
        .WIDTH (CHAN3_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ent_col),
        .wr_data (acc_new),
        .rd_en   (rd_en),
        .rd_addr (q_data[COL_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        pix     = unpack565(ent_hp);
        // strip start seeds from the pixel unless resuming stored columns
        acc     = (ent_ss && !cfg.resume_columns) ? pix : chan3_t'(rd_data);
        acc_new = iir_step(acc, pix, gain_of(cfg.smoothing));
        res     = cfg.vertical_enable ? pack565(acc_new) : ent_hp;
    end

    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    ent_next   = q_data;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (slot_free)
                begin
                    wr_en                         = cfg.vertical_enable;
                    out_valid_next                = 1'b1;
                    out_data_next.pixel_out       = res;
                    out_data_next.column_overflow = ent_ovf;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/rgb565_iir_blur.sv =====
// ----------------------------------------------------------------------------
// rgb565_iir_blur
// First-order IIR blur of RGB565 pixels in raster order, row then column pass.
//
// in_valid/in_stall/in_data carry one pixel per transfer with its row_start
// and strip_start flags; out_valid/out_stall/out_data carry one blurred pixel
// per input pixel, in order, with a column overflow flag.
// The front takes a pixel whenever the two-entry queue has room and runs the
// row pass in that cycle. The back pops one entry, reads the column memory
// (registered read) and, in ST_CALC once the output register is free,
// updates it and loads the output register; it pops no new entry before
// that, set by the read-then-write turn on the column memory. While out_stall
// is high the result holds in the output register, the back waits, the queue
// fills and in_stall rises once it is full. Reset clears the column index,
// the row accumulator and all handshake state and loads the register
// defaults; the column memory is not cleared and each column must be seeded
// by a strip start row before it is read. Configuration is written through
// cfg_we/cfg_index/cfg_data when idle; the user must keep to this, as the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module rgb565_iir_blur import rgbblur_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ENT_W = PIX_W + 2 + COL_W;

    cfg_t             cfg_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_valid;
    logic [ENT_W-1:0] q_wdata;
    logic [ENT_W-1:0] q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing         <= '0;
            cfg_reg.horizontal_enable <= 1'b1;
            cfg_reg.vertical_enable   <= 1'b1;
            cfg_reg.resume_columns    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SMOOTHING:         cfg_reg.smoothing         <= cfg_data;
                REG_HORIZONTAL_ENABLE: cfg_reg.horizontal_enable <= cfg_data[0];
                REG_VERTICAL_ENABLE:   cfg_reg.vertical_enable   <= cfg_data[0];
                REG_RESUME_COLUMNS:    cfg_reg.resume_columns    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    rgbblur_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_wdata)
    );

    rgbblur_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    rgbblur_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== tb/rgb565_iir_blur_tb.sv =====
// ----------------------------------------------------------------------------
// rgb565_iir_blur_tb
// Self-checking bench for the rgb565 row/column IIR blur. Pixels go in as
// strips of rows with random framing noise. A local model of both passes
// predicts each output pixel and its column overflow flag. Both handshake
// sides idle at random, and the configuration changes only between drained
// phases.
// ----------------------------------------------------------------------------
module rgb565_iir_blur_tb;
    import rgbblur_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SMOOTHING;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;

    // blur model state, mirrors the block after reset
    cfg_t   shadow = '{smoothing: 8'd0, horizontal_enable: 1'b1,
                       vertical_enable: 1'b1, resume_columns: 1'b0};
    chan3_t row_acc = '0;
    chan3_t col_acc [MAXW];
    bit     col_seeded [MAXW];
    int     col_idx = 0;

    out_item_t   blurred_q [$];
    int          errors     = 0;
    bit          idling     = 1'b1;
    int          stall_left = 0;
    logic [15:0] last_pixel = '0;

    rgb565_iir_blur DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic chan3_t expand565(logic [15:0] w);
        chan3_t c;
        logic [7:0] lo;
        lo  = (w != 16'h0) ? 8'h07 : 8'h00;
        c.b = {w[4:0], 3'b000} | lo;
        c.g = {w[10:5], 2'b00} | (lo & 8'h03);
        c.r = {w[15:11], 3'b000} | lo;
        return c;
    endfunction

    function automatic logic [15:0] compress565(chan3_t c);
        return {c.r[7:3], c.g[7:2], c.b[7:3]};
    endfunction

    // floor division by 256 through an arithmetic shift on a signed int
    function automatic logic [7:0] smooth_lane(logic [7:0] acc, logic [7:0] p, int gain);
        int delta;
        delta = ((int'(p) - int'(acc)) * gain) >>> 8;
        return 8'(int'(acc) + delta);
    endfunction

    function automatic chan3_t smooth_pixel(chan3_t acc, chan3_t p, int gain);
        chan3_t n;
        n.r = smooth_lane(acc.r, p.r, gain);
        n.g = smooth_lane(acc.g, p.g, gain);
        n.b = smooth_lane(acc.b, p.b, gain);
        return n;
    endfunction

    function automatic out_item_t blur_predict(in_item_t d);
        out_item_t   o;
        chan3_t      p;
        chan3_t      acc;
        logic [15:0] mid;
        int          gain;
        gain = 256 - int'(shadow.smoothing);
        o.column_overflow = 1'b0;
        if (d.row_start)
            col_idx = 0;
        else if (col_idx >= MAXW - 1)
        begin
            col_idx = MAXW - 1;
            o.column_overflow = 1'b1;
        end
        else
            col_idx++;
        mid = d.pixel_in;
        if (shadow.horizontal_enable)
        begin
            p = expand565(mid);
            if (d.row_start)
                row_acc = p;
            row_acc = smooth_pixel(row_acc, p, gain);
            mid = compress565(row_acc);
        end
        o.pixel_out = mid;
        if (shadow.vertical_enable)
        begin
            p = expand565(mid);
            acc = col_acc[col_idx];
            if (d.strip_start && !shadow.resume_columns)
                acc = p;
            acc = smooth_pixel(acc, p, gain);
            col_acc[col_idx] = acc;
            col_seeded[col_idx] = 1'b1;
            o.pixel_out = compress565(acc);
        end
        return o;
    endfunction

    function automatic logic [15:0] next_pixel();
        case ($urandom_range(0, 9))
            0: last_pixel = 16'h0000;
            1: last_pixel = 16'hffff;
            2, 3: last_pixel = last_pixel ^ (16'h1 << $urandom_range(0, 15));
            default: last_pixel = 16'($urandom);
        endcase
        return last_pixel;
    endfunction

    task automatic send_pixel(input logic [15:0] pix, input logic rs, input logic ss);
        in_item_t item;
        int       nxt;
        nxt = rs ? 0 : ((col_idx >= MAXW - 1) ? MAXW - 1 : col_idx + 1);
        // never read a column accumulator that no strip start has seeded
        if (shadow.vertical_enable && (!ss || shadow.resume_columns) && !col_seeded[nxt])
        begin
            if (!shadow.resume_columns)
                ss = 1'b1;
            else
                rs = 1'b1;
        end
        item.pixel_in    = pix;
        item.row_start   = rs;
        item.strip_start = ss;
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        blurred_q.push_back(blur_predict(item));
    endtask

    // stop sending and let every expected pixel come out
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] deg, input logic h, input logic v,
                              input logic r);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SMOOTHING;
        cfg_data  <= deg;
        @(posedge clk);
        cfg_index <= REG_HORIZONTAL_ENABLE;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= REG_VERTICAL_ENABLE;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge clk);
        cfg_index <= REG_RESUME_COLUMNS;
        cfg_data  <= CFG_DATA_W'(r);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        shadow.smoothing         = deg;
        shadow.horizontal_enable = h;
        shadow.vertical_enable   = v;
        shadow.resume_columns    = r;
    endtask

    task automatic log_mismatch(input string what, input out_item_t want,
                                input out_item_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected pixel %h ovf %b, got pixel %h ovf %b",
                     $realtime, what, want.pixel_out, want.column_overflow,
                     got.pixel_out, got.column_overflow);
    endtask

    // result checker and random output stall
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && !out_stall)
        begin
            if (blurred_q.size() == 0)
                log_mismatch("unexpected transfer", '0, out_data);
            else
            begin
                want = blurred_q.pop_front();
                if (want.pixel_out !== out_data.pixel_out ||
                    want.column_overflow !== out_data.column_overflow)
                    log_mismatch("pixel mismatch", want, out_data);
            end
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    // register defaults, and a first pixel without row start from a zero row state
    task automatic test_reset_defaults();
        send_pixel(16'h1234, 1'b0, 1'b1);
        send_pixel(16'h0000, 1'b1, 1'b1);
        send_pixel(16'hffff, 1'b0, 1'b1);
        send_pixel(16'h0001, 1'b0, 1'b1);
        send_pixel(16'h8000, 1'b1, 1'b0);
        send_pixel(16'h07e0, 1'b0, 1'b0);
    endtask

    task automatic test_degree_extremes();
        wait_drain();
        set_config(8'd255, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
            send_pixel(i[0] ? 16'h0000 : 16'hffff, i % 4 == 0, i < 4);
        send_pixel(16'hf800, 1'b1, 1'b0);
        send_pixel(16'h001f, 1'b0, 1'b0);
    endtask

    task automatic test_pass_selection();
        wait_drain();
        set_config(8'd128, 1'b0, 1'b1, 1'b0);
        send_pixel(16'hffff, 1'b1, 1'b0);
        send_pixel(16'h0000, 1'b0, 1'b0);
        wait_drain();
        set_config(8'd128, 1'b1, 1'b0, 1'b0);
        send_pixel(16'h5555, 1'b1, 1'b0);
        send_pixel(16'haaaa, 1'b0, 1'b1);
        wait_drain();
        set_config(8'd200, 1'b0, 1'b0, 1'b0);
        send_pixel(16'h7bef, 1'b1, 1'b1);
        send_pixel(16'h8410, 1'b0, 1'b0);
    endtask

    task automatic test_resume_columns();
        wait_drain();
        set_config(8'd64, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++)
            send_pixel(next_pixel(), i == 0, 1'b1);
    endtask

    // strips of well-formed rows with random content, plus framing noise
    task automatic test_random_strips();
        int       sent;
        int       width;
        int       rows;
        logic [7:0] deg;
        logic     rs;
        logic     ss;
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drain();
            deg = (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : (ph == 2) ? 8'd1 :
                  8'($urandom_range(0, 255));
            set_config(deg, (ph == 3) ? 1'b0 : ($urandom_range(0, 4) != 0),
                       (ph == 4) ? 1'b0 : ($urandom_range(0, 4) != 0),
                       (ph >= 5) ? 1'($urandom_range(0, 1)) : 1'b0);
            idling = (ph < 6);
            sent = 0;
            while (sent < 30)
            begin
                width = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) :
                        $urandom_range(1, 40);
                rows = $urandom_range(1, 4);
                for (int r = 0; r < rows; r++)
                begin
                    for (int c = 0; c < width; c++)
                    begin
                        rs = (c == 0);
                        ss = (r == 0);
                        if ($urandom_range(0, 19) == 0)
                        begin
                            rs = 1'($urandom_range(0, 1));
                            ss = 1'($urandom_range(0, 1));
                        end
                        send_pixel(next_pixel(), rs, ss);
                        sent++;
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    wait_drain();
            end
        end
    endtask

    // one row longer than the column memory, then rows that reuse it
    task automatic test_column_saturation();
        wait_drain();
        set_config(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
        idling = 1'b0;
        for (int i = 0; i < MAXW + 3; i++)
            send_pixel(next_pixel(), i == 0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_pixel(next_pixel(), i == 0, 1'b0);
        wait_drain();
        // every column is seeded now
        set_config(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 48; i++)
            send_pixel(next_pixel(), i % 16 == 0, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_degree_extremes();
        test_pass_selection();
        test_resume_columns();
        test_random_strips();
        test_column_saturation();
        wait_drain();
        repeat (16) @(posedge clk);
        if (blurred_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(600_000 * 20);
        $display("== FAIL ==");
        $finish;
    end

endmodule
